FILE: rtl/core/fswp_pkg.sv
`timescale 1ns / 1ps
package fswp_pkg;

   localparam int MAX_NODES_DEF = 1048576;
   localparam int FIFO_DEPTH = 4;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_MODE        = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DIR_X       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DIR_Y       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DIR_Z       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_WATER_LEVEL = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS      = 3'd5;

   localparam logic MODE_AVERAGE = 1'b0;
   localparam logic MODE_NEAREST = 1'b1;

   typedef struct packed {
      logic               mode;
      logic signed [15:0] dir_x;
      logic signed [15:0] dir_y;
      logic signed [15:0] dir_z;
      logic signed [31:0] water_level;
      logic        [30:0] radius;
   } cfg_type;

   typedef struct packed {
      logic               hit;
      logic signed [31:0] height;
      logic        [63:0] dist_sq;
      logic               last;
      logic               mode;
   } rec_type;

   typedef enum logic [1:0] {
      F_IDLE,
      F_RUN,
      F_PUSH
   } front_state_type;

   typedef enum logic [2:0] {
      B_ACC,
      B_FIN,
      B_DIV,
      B_OUT
   } back_state_type;

endpackage

FILE: rtl/core/fswp_fifo.sv
`timescale 1ns / 1ps
module fswp_fifo
   import fswp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rec_type push_data,
   output logic    full,
   input  logic    pop,
   output rec_type pop_data,
   output logic    not_empty
);

   localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

   rec_type            mem_ff [FIFO_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full      = (count_ff == CNT_W'(FIFO_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push && !full) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop && not_empty) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if ((push && !full) && !(pop && not_empty)) begin
         count_in = count_ff + 1'b1;
      end else if (!(push && !full) && (pop && not_empty)) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push && !full) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: rtl/core/fswp_front.sv
`timescale 1ns / 1ps
module fswp_front
   import fswp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cfg_type       cfg,
   input  logic          in_valid,
   output logic          in_ready,
   input  logic [191:0]  in_data,
   input  logic [2:0]    in_flags,
   input  logic          in_last,
   output logic          push,
   output rec_type       push_data,
   input  logic          full
);

   front_state_type     state_ff, state_in;
   logic [3:0]          step_ff, step_in;
   cfg_type             cfg_ff;
   logic signed [32:0]  n_ff [3];
   logic signed [32:0]  r_ff [3];
   logic                ok_ff, last_ff;
   logic signed [50:0]  acc_ff, acc_in;
   logic        [30:0]  c_ff [3];
   logic                far_ff, far_in;
   logic        [63:0]  dsq_ff;
   logic        [63:0]  rsq_ff;
   logic signed [31:0]  h_ff;

   logic signed [15:0]  mul_a;
   logic signed [32:0]  mul_b;
   logic signed [48:0]  prod;
   logic [1:0]          acc_op;
   logic        [30:0]  sq_a;
   logic        [61:0]  sq;
   logic        [50:0]  acc_mag;
   logic signed [36:0]  h_wide;
   logic signed [37:0]  h_sub;
   logic signed [31:0]  h_sat;

   localparam logic [1:0] OP_FIRST = 2'd0;
   localparam logic [1:0] OP_ADD   = 2'd1;
   localparam logic [1:0] OP_SUB   = 2'd2;

   always_comb begin
      mul_a  = cfg_ff.dir_x;
      mul_b  = n_ff[0];
      acc_op = OP_FIRST;
      case (step_ff)
         4'd0: begin mul_a = cfg_ff.dir_y; mul_b = r_ff[2]; acc_op = OP_FIRST; end
         4'd1: begin mul_a = cfg_ff.dir_z; mul_b = r_ff[1]; acc_op = OP_SUB;   end
         4'd2: begin mul_a = cfg_ff.dir_z; mul_b = r_ff[0]; acc_op = OP_FIRST; end
         4'd3: begin mul_a = cfg_ff.dir_x; mul_b = r_ff[2]; acc_op = OP_SUB;   end
         4'd4: begin mul_a = cfg_ff.dir_x; mul_b = r_ff[1]; acc_op = OP_FIRST; end
         4'd5: begin mul_a = cfg_ff.dir_y; mul_b = r_ff[0]; acc_op = OP_SUB;   end
         4'd6: begin mul_a = cfg_ff.dir_x; mul_b = n_ff[0]; acc_op = OP_FIRST; end
         4'd7: begin mul_a = cfg_ff.dir_y; mul_b = n_ff[1]; acc_op = OP_ADD;   end
         4'd8: begin mul_a = cfg_ff.dir_z; mul_b = n_ff[2]; acc_op = OP_ADD;   end
         default: begin mul_a = cfg_ff.dir_x; mul_b = n_ff[0]; acc_op = OP_ADD; end
      endcase
      prod = 49'(mul_a * mul_b);
      case (acc_op)
         OP_FIRST: acc_in = 51'(prod);
         OP_SUB:   acc_in = acc_ff - 51'(prod);
         default:  acc_in = acc_ff + 51'(prod);
      endcase
      acc_mag = acc_in[50] ? 51'(-acc_in) : 51'(acc_in);
      far_in  = far_ff | (acc_mag[50:45] != '0);

      case (step_ff)
         4'd9:    sq_a = c_ff[0];
         4'd10:   sq_a = c_ff[1];
         4'd11:   sq_a = c_ff[2];
         default: sq_a = cfg_ff.radius;
      endcase
      sq = 62'(sq_a) * 62'(sq_a);

      h_wide = 37'((acc_ff + 51'sd8192) >>> 14);
      h_sub  = 38'(h_wide) - 38'(cfg_ff.water_level);
      if (h_sub > 38'sd2147483647) begin
         h_sat = 32'sh7FFFFFFF;
      end else if (h_sub < -38'sd2147483648) begin
         h_sat = 32'sh80000000;
      end else begin
         h_sat = h_sub[31:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      in_ready = (state_ff == F_IDLE);
      push     = 1'b0;
      unique case (state_ff)
         F_IDLE: begin
            step_in = '0;
            if (in_valid) begin
               state_in = F_RUN;
            end
         end
         F_RUN: begin
            step_in = step_ff + 1'b1;
            if (step_ff == 4'd12) begin
               state_in = F_PUSH;
            end
         end
         F_PUSH: begin
            if (!full) begin
               push     = 1'b1;
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   assign push_data.hit     = ok_ff && !far_ff && (dsq_ff < rsq_ff);
   assign push_data.height  = h_ff;
   assign push_data.dist_sq = dsq_ff;
   assign push_data.last    = last_ff;
   assign push_data.mode    = cfg_ff.mode;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == F_IDLE && in_valid) begin
         cfg_ff  <= cfg;
         n_ff[0] <= 33'(signed'(in_data[31:0]));
         n_ff[1] <= 33'(signed'(in_data[63:32]));
         n_ff[2] <= 33'(signed'(in_data[95:64]));
         r_ff[0] <= 33'(signed'(in_data[31:0]))   - 33'(signed'(in_data[127:96]));
         r_ff[1] <= 33'(signed'(in_data[63:32]))  - 33'(signed'(in_data[159:128]));
         r_ff[2] <= 33'(signed'(in_data[95:64]))  - 33'(signed'(in_data[191:160]));
         ok_ff   <= in_flags[0] && !in_flags[1] && !in_flags[2];
         last_ff <= in_last;
         far_ff  <= 1'b0;
         dsq_ff  <= '0;
      end else if (state_ff == F_RUN) begin
         if (step_ff <= 4'd8) begin
            acc_ff <= acc_in;
         end
         case (step_ff)
            4'd1: begin c_ff[0] <= acc_mag[44:14]; far_ff <= far_in; end
            4'd3: begin c_ff[1] <= acc_mag[44:14]; far_ff <= far_in; end
            4'd5: begin c_ff[2] <= acc_mag[44:14]; far_ff <= far_in; end
            4'd9, 4'd10, 4'd11: dsq_ff <= dsq_ff + 64'(sq);
            4'd12: rsq_ff <= 64'(sq);
            default: ;
         endcase
         if (step_ff == 4'd9) begin
            h_ff <= h_sat;
         end
      end
   end

endmodule

FILE: rtl/core/fswp_back.sv
`timescale 1ns / 1ps
module fswp_back
   import fswp_pkg::*;
#(
   parameter int MAX_NODES = MAX_NODES_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         rec_valid,
   input  rec_type      rec,
   output logic         pop,
   output logic         out_valid,
   input  logic         out_ready,
   output logic [31:0]  out_height,
   output logic [20:0]  out_count,
   output logic         out_found
);

   localparam logic [20:0] COUNT_CAP =
      (MAX_NODES < 2097151) ? 21'(MAX_NODES) : 21'h1FFFFF;

   back_state_type      state_ff, state_in;
   logic signed [63:0]  sum_ff;
   logic        [20:0]  count_ff;
   logic        [63:0]  best_dsq_ff;
   logic signed [31:0]  best_h_ff;
   logic                mode_ff;
   logic [64:0]         quo_ff;
   logic [21:0]         rem_ff;
   logic [6:0]          bit_ff;
   logic                neg_ff;
   logic [31:0]         res_ff, res_in;
   logic                out_valid_ff;
   logic [31:0]         out_height_ff;
   logic [20:0]         out_count_ff;

   logic signed [64:0]  sum_ext;
   logic signed [63:0]  sum_sat;
   logic [63:0]         sum_mag;
   logic [21:0]         rem_shift;
   logic                rem_ge;
   logic [64:0]         q_fin;
   logic                out_free;

   assign out_valid  = out_valid_ff;
   assign out_height = out_height_ff;
   assign out_count  = out_count_ff;
   assign out_found  = (out_count_ff != '0);
   assign out_free   = !out_valid_ff || out_ready;
   assign pop        = rec_valid && (state_ff == B_ACC);

   always_comb begin
      sum_ext = 65'(sum_ff) + 65'(rec.height);
      if (sum_ext[64] != sum_ext[63]) begin
         sum_sat = sum_ext[64] ? 64'sh8000000000000000 : 64'sh7FFFFFFFFFFFFFFF;
      end else begin
         sum_sat = sum_ext[63:0];
      end
      sum_mag   = sum_ff[63] ? 64'(-sum_ff) : 64'(sum_ff);
      rem_shift = {rem_ff[20:0], quo_ff[64]};
      rem_ge    = (rem_shift >= 22'(count_ff));
      q_fin     = {quo_ff[63:0], rem_ge};
      if (neg_ff) begin
         res_in = (q_fin >= 65'h80000000) ? 32'h80000000 : 32'(-q_fin[31:0]);
      end else begin
         res_in = (q_fin >= 65'h80000000) ? 32'h7FFFFFFF : q_fin[31:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_ACC:   if (pop && rec.last) state_in = B_FIN;
         B_FIN: begin
            if (count_ff == '0 || mode_ff == MODE_NEAREST) begin
               state_in = B_OUT;
            end else begin
               state_in = B_DIV;
            end
         end
         B_DIV:   if (bit_ff == 7'd0) state_in = B_OUT;
         B_OUT:   if (out_free) state_in = B_ACC;
         default: state_in = B_ACC;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_ACC;
         sum_ff       <= '0;
         count_ff     <= '0;
         best_dsq_ff  <= '1;
         best_h_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == B_OUT && out_free) begin
            out_valid_ff <= 1'b1;
         end else if (out_valid_ff && out_ready) begin
            out_valid_ff <= 1'b0;
         end
         if (pop) begin
            mode_ff <= rec.mode;
            if (rec.hit) begin
               if (count_ff < COUNT_CAP) begin
                  count_ff <= count_ff + 1'b1;
                  sum_ff   <= sum_sat;
               end
               if (rec.dist_sq < best_dsq_ff) begin
                  best_dsq_ff <= rec.dist_sq;
                  best_h_ff   <= rec.height;
               end
            end
         end
         if (state_ff == B_OUT && out_free) begin
            sum_ff       <= '0;
            count_ff     <= '0;
            best_dsq_ff  <= '1;
            best_h_ff    <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         B_FIN: begin
            quo_ff <= 65'(sum_mag) + 65'(count_ff[20:1]);
            rem_ff <= '0;
            bit_ff <= 7'd64;
            neg_ff <= sum_ff[63];
            if (count_ff == '0) begin
               res_ff <= '0;
            end else begin
               res_ff <= best_h_ff;
            end
         end
         B_DIV: begin
            rem_ff <= rem_ge ? rem_shift - 22'(count_ff) : rem_shift;
            quo_ff <= {quo_ff[63:0], rem_ge};
            bit_ff <= bit_ff - 1'b1;
         end
         B_OUT: begin
            if (out_free) begin
               out_height_ff <= res_ff;
               out_count_ff  <= count_ff;
            end
         end
         default: ;
      endcase
      if (state_ff == B_DIV && bit_ff == 7'd0) begin
         res_ff <= res_in;
      end
   end

endmodule

FILE: rtl/core/free_surface_wave_probe_top.sv
`timescale 1ns / 1ps
// Channel | Direction | Transaction
// req_*   | in        | one mesh node with its probe point and flags
// rsp_*   | out       | one wave height per node set
// csr_*   | in        | register write, no read-back
// The front sequencer takes one node at a time (one shared 16x33 multiplier, one
// squarer); the back end retires one queued node per cycle while accumulating. After the
// last node the mean uses a 65-step one-bit-per-cycle divider; nearest mode skips it.
// Reset is synchronous and active high; control and configuration registers return to their reset values.
// A full queue stalls the front; a stalled result holds the back end.
module free_surface_wave_probe_top
   import fswp_pkg::*;
#(
   parameter int MAX_NODES = MAX_NODES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // node_x, node_y, node_z, probe_x, probe_y, probe_z
   input  logic [191:0]          req_tdata,
   // surface, rigid, isolated
   input  logic [2:0]            req_tuser,
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // height, node_count, zero fill
   output logic [55:0]           rsp_tdata,
   // found
   output logic                  rsp_tuser,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type     cfg_ff;
   logic        push, full, pop, not_empty;
   rec_type     push_data, pop_data;
   logic [31:0] out_height;
   logic [20:0] out_count;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode          <= MODE_AVERAGE;
         cfg_ff.dir_x         <= '0;
         cfg_ff.dir_y         <= '0;
         cfg_ff.dir_z         <= 16'sd16384;
         cfg_ff.water_level   <= '0;
         cfg_ff.radius        <= 31'd131072;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MODE:        cfg_ff.mode          <= csr_wdata[0];
            CSR_DIR_X:       cfg_ff.dir_x         <= csr_wdata[15:0];
            CSR_DIR_Y:       cfg_ff.dir_y         <= csr_wdata[15:0];
            CSR_DIR_Z:       cfg_ff.dir_z         <= csr_wdata[15:0];
            CSR_WATER_LEVEL: cfg_ff.water_level   <= csr_wdata[31:0];
            CSR_RADIUS:      cfg_ff.radius        <= csr_wdata[30:0];
            default: ;
         endcase
      end
   end

   fswp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (req_tdata),
      .in_flags  (req_tuser),
      .in_last   (req_tlast),
      .push      (push),
      .push_data (push_data),
      .full      (full)
   );

   fswp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .pop_data  (pop_data),
      .not_empty (not_empty)
   );

   fswp_back #(
      .MAX_NODES (MAX_NODES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .rec_valid  (not_empty),
      .rec        (pop_data),
      .pop        (pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_height (out_height),
      .out_count  (out_count),
      .out_found  (rsp_tuser)
   );

   assign rsp_tdata = {3'b000, out_count, out_height};

endmodule
